@@ rtl/core/arp_pkg.sv @@
// Shared constants for the ARP spoofing checker.
`default_nettype none
package arp_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    // Item kinds
    localparam logic [1:0] ACT_CHECK = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_INVAL = 2'd2;

    // Header alert codes
    localparam logic [1:0] HDR_NONE      = 2'd0;
    localparam logic [1:0] HDR_UNICAST   = 2'd1;
    localparam logic [1:0] HDR_SRC_MISM  = 2'd2;
    localparam logic [1:0] HDR_DST_MISM  = 2'd3;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;
    localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int ENTRY_W = IP_W + MAC_W;

endpackage
`default_nettype wire

@@ rtl/core/arp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/arp_spoof_checker.sv @@
// Top level of the ARP spoofing checker with its host address table.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | to block  | i_in_valid / o_in_stall   | action, slot, entry, ARP fields
//  out     | from block| o_out_valid / i_out_stall | checked, alerts, hit, total
//  cfg     | to block  | i_cfg_we                  | table check enable
//
// Table writes, invalidates, non-ARP items and checks with the table check off
// go from accept straight to result load. A table check walks the host RAM one
// entry per cycle through its single read port and stops early when an entry
// matches. Reset clears the valid bits, the packet counter and the register; no
// clearing pass. A stalled output delays the result load and holds the block
// busy.
`default_nettype none
module arp_spoof_checker #(
    parameter int TABLE_ENTRIES = arp_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_in_action,
    input  wire logic [3:0]  i_in_slot,
    input  wire logic [31:0] i_in_entry_ip,
    input  wire logic [47:0] i_in_entry_mac,
    input  wire logic [15:0] i_in_hw_type,
    input  wire logic [15:0] i_in_proto_type,
    input  wire logic [15:0] i_in_opcode,
    input  wire logic [47:0] i_in_eth_src,
    input  wire logic [47:0] i_in_eth_dst,
    input  wire logic [47:0] i_in_sender_mac,
    input  wire logic [47:0] i_in_target_mac,
    input  wire logic [31:0] i_in_sender_ip,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_out_checked,
    output logic [1:0]       o_out_header_alert,
    output logic             o_out_overwrite_alert,
    output logic             o_out_table_hit,
    output logic [31:0]      o_out_packet_total
);

    import arp_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state r_state;

    logic                     r_check_ovr;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0]              r_cnt;

    // captured item
    logic        r_checked;
    logic [1:0]  r_hdr;
    logic [31:0] r_sip;
    logic [47:0] r_esrc;
    logic [47:0] r_sha;

    // scan sequencer
    logic [AW-1:0] r_ridx;
    logic          r_issue;
    logic          r_cmp_vld;
    logic [AW-1:0] r_cmp_idx;
    logic          r_hit;
    logic          r_ovr;

    // output register
    logic        r_out_valid;
    logic        r_out_checked;
    logic [1:0]  r_out_hdr;
    logic        r_out_ovr;
    logic        r_out_hit;
    logic [31:0] r_out_total;

    logic               w_accept;
    logic               w_is_arp;
    logic               w_slot_ok;
    logic [1:0]         w_hdr;
    logic               w_ram_we;
    logic [ENTRY_W-1:0] w_rdata;
    logic               w_match;
    logic               w_mac_diff;
    logic               w_out_free;

    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_is_arp  = (i_in_action == ACT_CHECK) && (i_in_hw_type == HW_ETHERNET)
                       && (i_in_proto_type == PROTO_IPV4);
    assign w_slot_ok = 32'(i_in_slot) < 32'(TABLE_ENTRIES);
    assign w_ram_we  = w_accept && (i_in_action == ACT_WRITE) && w_slot_ok;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_hdr = HDR_NONE;
        if (i_in_opcode == OP_REQUEST) begin
            if (i_in_eth_dst != MAC_BCAST) begin
                w_hdr = HDR_UNICAST;
            end else if (i_in_eth_src != i_in_sender_mac) begin
                w_hdr = HDR_SRC_MISM;
            end
        end else if (i_in_opcode == OP_REPLY) begin
            if (i_in_eth_src != i_in_sender_mac) begin
                w_hdr = HDR_SRC_MISM;
            end else if (i_in_eth_dst != i_in_target_mac) begin
                w_hdr = HDR_DST_MISM;
            end
        end
    end

    arp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_host_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(i_in_slot)),
        .i_wdata ({i_in_entry_ip, i_in_entry_mac}),
        .i_raddr (r_ridx),
        .o_rdata (w_rdata)
    );

    // shared compare unit: IP match and MAC check on the entry read last cycle
    assign w_match    = r_cmp_vld && r_valid[r_cmp_idx]
                        && (w_rdata[ENTRY_W-1:MAC_W] == r_sip);
    assign w_mac_diff = (w_rdata[MAC_W-1:0] != r_esrc) || (w_rdata[MAC_W-1:0] != r_sha);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_check_ovr <= 1'b0;
            r_valid     <= '0;
            r_cnt       <= '0;
            r_issue     <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_check_ovr <= i_cfg_wdata;
            end
            // drop the taken result unless a new one loads this cycle
            if (r_out_valid && !i_out_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_checked <= w_is_arp;
                        r_hdr     <= w_is_arp ? w_hdr : HDR_NONE;
                        r_sip     <= i_in_sender_ip;
                        r_esrc    <= i_in_eth_src;
                        r_sha     <= i_in_sender_mac;
                        r_hit     <= 1'b0;
                        r_ovr     <= 1'b0;
                        r_ridx    <= '0;
                        r_cmp_vld <= 1'b0;
                        if (w_is_arp) begin
                            r_cnt <= r_cnt + 32'd1;
                        end
                        if (i_in_action == ACT_WRITE && w_slot_ok) begin
                            r_valid[AW'(i_in_slot)] <= 1'b1;
                        end
                        if (i_in_action == ACT_INVAL && w_slot_ok) begin
                            r_valid[AW'(i_in_slot)] <= 1'b0;
                        end
                        if (w_is_arp && r_check_ovr) begin
                            r_issue <= 1'b1;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    // issue one read per cycle, compare each entry in the cycle after its read
                    r_cmp_idx <= r_ridx;
                    if (r_issue && (r_ridx != LAST_IDX)) begin
                        r_ridx <= r_ridx + AW'(1);
                    end
                    if (w_match) begin
                        r_hit     <= 1'b1;
                        r_ovr     <= w_mac_diff;
                        r_issue   <= 1'b0;
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_FIN;
                    end else begin
                        r_cmp_vld <= r_issue;
                        if (r_issue && (r_ridx == LAST_IDX)) begin
                            r_issue <= 1'b0;
                        end
                        if (r_cmp_vld && (r_cmp_idx == LAST_IDX)) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_checked <= r_checked;
                        r_out_hdr     <= r_hdr;
                        r_out_ovr     <= r_ovr;
                        r_out_hit     <= r_hit;
                        r_out_total   <= r_cnt;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall            = (r_state != S_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_out_checked         = r_out_checked;
    assign o_out_header_alert    = r_out_hdr;
    assign o_out_overwrite_alert = r_out_ovr;
    assign o_out_table_hit       = r_out_hit;
    assign o_out_packet_total    = r_out_total;

endmodule
`default_nettype wire

@@ rtl/core/arp_spoof_checker_chk.sv @@
// Port-level checker for the ARP spoofing checker, bound to the top level.
`default_nettype none
module arp_spoof_checker_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_out_checked,
    input wire logic [1:0]  o_out_header_alert,
    input wire logic        o_out_overwrite_alert,
    input wire logic        o_out_table_hit,
    input wire logic [31:0] o_out_packet_total
);

    import arp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_packet_total)
        && $stable(o_out_header_alert) && $stable(o_out_table_hit))
        else $error("stalled result changed");

    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped under stall");

    // one transaction at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("accepted back to back");

    a_unchecked_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_checked |-> o_out_header_alert == HDR_NONE
        && !o_out_overwrite_alert && !o_out_table_hit)
        else $error("alert on an uninspected item");

    a_ovr_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_overwrite_alert |-> o_out_table_hit && o_out_checked)
        else $error("overwrite alert without table hit");

endmodule

bind arp_spoof_checker arp_spoof_checker_chk u_chk (.*);
`default_nettype wire
